// File: src/histogram_peak_feature_scan_macros.svh
// Assertion macros shared by the histogram peak scan checker.
`ifndef HISTOGRAM_PEAK_FEATURE_SCAN_MACROS_SVH
`define HISTOGRAM_PEAK_FEATURE_SCAN_MACROS_SVH

// Property checked on every clock edge outside reset.
`define HPFS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("histogram peak scan check failed");

// Property checked on every clock edge, reset included.
`define HPFS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("histogram peak scan reset check failed");

`endif

// File: src/hpfs_pkg.sv
// Shared constants and types of the histogram peak feature scan.
`default_nettype none

package hpfs_pkg;

    localparam int MAX_BINS    = 65536;
    localparam int CNT_W       = 24;
    localparam int SUM_W       = 28;
    localparam int IDX_W       = 17;
    localparam int RF_W        = 5;
    localparam int FILL_W      = 4;
    localparam int RF_MAX      = 16;
    localparam int RF_RESET    = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W       = IDX_W + RF_W + 1;
    localparam int PROD_W      = IDX_W + RF_W;

    // One classified input word: a completed rebinned bin and/or the end mark.
    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
        logic [IDX_W-1:0] idx;
        logic             last;
    } bin_evt_t;

endpackage

`default_nettype wire

// File: src/histogram_peak_feature_scan.sv
// Top level of the histogram peak feature scan.
//
//  Channel  Direction  Payload
//  s_       in         tdata = bin_count[23:0], tlast = last_bin
//  m_       out        tdata = pedestal, dip, peak, half_max (17 bits each), tuser = status
//  cfg_     in         data = rebin_factor[4:0]
//
// One bin word is taken per cycle while the queue has room; the front end sums one rebin
// group step a cycle. The end mark, leaving the queue, loads the result register.
// A four-word queue lets the front end keep taking bins while a result is stalled.
// Reset clears all scan state and sets the rebin factor to 4.
`default_nettype none

module histogram_peak_feature_scan (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // bin_count[23:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // pedestal_bin, dip_bin, peak_bin, half_max_bin, zeros
    output logic             m_tuser,   // status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import hpfs_pkg::*;

    logic [RF_W-1:0]  rebin_reg;
    logic [RF_W-1:0]  rebin_eff;
    logic             q_push, q_pop, q_can_push, q_valid;
    bin_evt_t         push_evt, head_evt;
    logic [IDX_W-1:0] ped, dip, peak, half;

    assign cfg_ready = 1'b1;

    // Rebin factor register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rebin_reg <= RF_W'(RF_RESET);
        end else if (cfg_valid && cfg_ready) begin
            rebin_reg <= cfg_data;
        end
    end

    // Zero acts as one, values above the maximum act as the maximum.
    always_comb begin
        if (rebin_reg == '0) begin
            rebin_eff = RF_W'(1);
        end else if (rebin_reg > RF_W'(RF_MAX)) begin
            rebin_eff = RF_W'(RF_MAX);
        end else begin
            rebin_eff = rebin_reg;
        end
    end

    hpfs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rebin    (rebin_eff),
        .in_valid (s_tvalid),
        .in_count (s_tdata),
        .in_last  (s_tlast),
        .q_ready  (q_can_push),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_evt    (push_evt)
    );

    hpfs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_evt  (push_evt),
        .pop       (q_pop),
        .can_push  (q_can_push),
        .not_empty (q_valid),
        .head_evt  (head_evt)
    );

    hpfs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rebin        (rebin_eff),
        .q_valid      (q_valid),
        .q_evt        (head_evt),
        .q_pop        (q_pop),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (m_tuser),
        .out_pedestal (ped),
        .out_dip      (dip),
        .out_peak     (peak),
        .out_half     (half)
    );

    assign m_tdata = {4'b0000, half, peak, dip, ped};

endmodule

`default_nettype wire

// File: src/hpfs_front.sv
// Front end: accepts bin words, sums rebin groups and classifies each word.
`default_nettype none

module hpfs_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [hpfs_pkg::RF_W-1:0]   rebin,
    input  wire logic                        in_valid,
    input  wire logic [hpfs_pkg::CNT_W-1:0]  in_count,
    input  wire logic                        in_last,
    input  wire logic                        q_ready,
    output logic                             in_ready,
    output logic                             q_push,
    output hpfs_pkg::bin_evt_t               q_evt
);
    import hpfs_pkg::*;

    logic [SUM_W-1:0]  group_sum_reg, group_sum_next;
    logic [FILL_W-1:0] group_fill_reg, group_fill_next;
    logic [IDX_W-1:0]  rebinned_index_reg, rebinned_index_next;
    logic [PROD_W-1:0] base_pos;
    logic [POS_W-1:0]  pos;
    logic [SUM_W-1:0]  sum_add;
    logic              in_range;
    logic              group_done;
    logic              accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    // Position of this bin in the original histogram.
    assign base_pos = PROD_W'(rebinned_index_reg) * PROD_W'(rebin);
    assign pos      = {1'b0, base_pos} + POS_W'(group_fill_reg);
    assign in_range = pos < POS_W'(MAX_BINS);
    assign sum_add  = group_sum_reg + SUM_W'(in_count);
    assign group_done = in_range && (({1'b0, group_fill_reg} + RF_W'(1)) >= rebin);

    // Next accumulator state and the word handed to the back end.
    always_comb begin
        group_sum_next      = group_sum_reg;
        group_fill_next     = group_fill_reg;
        rebinned_index_next = rebinned_index_reg;
        if (in_range) begin
            if (group_done) begin
                group_sum_next      = '0;
                group_fill_next     = '0;
                rebinned_index_next = rebinned_index_reg + IDX_W'(1);
            end else begin
                group_sum_next  = sum_add;
                group_fill_next = group_fill_reg + FILL_W'(1);
            end
        end
        q_evt.done = group_done;
        q_evt.sum  = sum_add;
        q_evt.idx  = rebinned_index_next;
        q_evt.last = in_last;
        q_push     = accept && (group_done || in_last);
    end

    // Accumulator registers; the end mark restarts the histogram.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_sum_reg      <= '0;
            group_fill_reg     <= '0;
            rebinned_index_reg <= '0;
        end else if (accept) begin
            if (in_last) begin
                group_sum_reg      <= '0;
                group_fill_reg     <= '0;
                rebinned_index_reg <= '0;
            end else begin
                group_sum_reg      <= group_sum_next;
                group_fill_reg     <= group_fill_next;
                rebinned_index_reg <= rebinned_index_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/hpfs_queue.sv
// Short register queue between the front end and the scan back end.
`default_nettype none

module hpfs_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire hpfs_pkg::bin_evt_t push_evt,
    input  wire logic               pop,
    output logic                    can_push,
    output logic                    not_empty,
    output hpfs_pkg::bin_evt_t      head_evt
);
    import hpfs_pkg::*;

    bin_evt_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign can_push  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && can_push;
    assign do_pop    = pop && not_empty;
    assign head_evt  = mem_reg[rd_ptr_reg];

    // Storage words carry no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_evt;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/hpfs_back.sv
// Back end: forward feature scan over rebinned bins and the result register.
`default_nettype none

module hpfs_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [hpfs_pkg::RF_W-1:0]   rebin,
    input  wire logic                        q_valid,
    input  wire hpfs_pkg::bin_evt_t          q_evt,
    output logic                             q_pop,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic                             out_status,
    output logic [hpfs_pkg::IDX_W-1:0]       out_pedestal,
    output logic [hpfs_pkg::IDX_W-1:0]       out_dip,
    output logic [hpfs_pkg::IDX_W-1:0]       out_peak,
    output logic [hpfs_pkg::IDX_W-1:0]       out_half
);
    import hpfs_pkg::*;

    typedef enum logic [2:0] {
        SEEK_PED,
        SEEK_FALL,
        SEEK_DIP,
        SEEK_PEAK,
        SEEK_HALF,
        SCAN_DONE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [SUM_W-1:0]  prev_reg, prev_next;
    logic [SUM_W-1:0]  ref_reg, ref_next;
    logic [IDX_W-1:0]  ped_reg, ped_next;
    logic [IDX_W-1:0]  dip_reg, dip_next;
    logic [IDX_W-1:0]  peak_reg, peak_next;
    logic [IDX_W-1:0]  half_reg, half_next;
    logic              out_valid_reg;
    logic              out_status_reg;
    logic [IDX_W-1:0]  out_ped_reg, out_dip_reg, out_peak_reg, out_half_reg;
    logic [IDX_W-1:0]  half_sel;
    logic [PROD_W-1:0] ped_prod, dip_prod, peak_prod, half_prod;
    logic              found;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = q_valid && (!q_evt.last || out_free);

    // Scan step for one completed rebinned bin.
    always_comb begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        ref_next   = ref_reg;
        ped_next   = ped_reg;
        dip_next   = dip_reg;
        peak_next  = peak_reg;
        half_next  = half_reg;
        if (q_evt.done) begin
            unique case (phase_reg)
                SEEK_PED: begin
                    if (q_evt.sum != '0) begin
                        ped_next   = q_evt.idx;
                        phase_next = SEEK_FALL;
                    end
                end
                SEEK_FALL: begin
                    if (q_evt.sum < prev_reg) begin
                        phase_next = SEEK_DIP;
                    end
                end
                SEEK_DIP: begin
                    if (q_evt.sum > prev_reg) begin
                        dip_next   = q_evt.idx;
                        phase_next = SEEK_PEAK;
                    end
                end
                SEEK_PEAK: begin
                    if (q_evt.sum < prev_reg) begin
                        peak_next  = q_evt.idx;
                        ref_next   = q_evt.sum;
                        phase_next = SEEK_HALF;
                    end
                end
                SEEK_HALF: begin
                    if ({q_evt.sum, 1'b0} < {1'b0, ref_reg}) begin
                        half_next  = q_evt.idx;
                        phase_next = SCAN_DONE;
                    end
                end
                SCAN_DONE: begin
                end
                default: begin
                end
            endcase
            prev_next = q_evt.sum;
        end
    end

    // Report fields in original-bin units.
    assign found     = (phase_next == SEEK_HALF) || (phase_next == SCAN_DONE);
    assign half_sel  = (phase_next == SCAN_DONE) ? half_next : q_evt.idx;
    assign ped_prod  = PROD_W'(ped_next) * PROD_W'(rebin);
    assign dip_prod  = PROD_W'(dip_next) * PROD_W'(rebin);
    assign peak_prod = PROD_W'(peak_next) * PROD_W'(rebin);
    assign half_prod = PROD_W'(half_sel) * PROD_W'(rebin);

    // Scan state and the result register; the end mark loads the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= SEEK_PED;
            prev_reg       <= '0;
            ref_reg        <= '0;
            ped_reg        <= '0;
            dip_reg        <= '0;
            peak_reg       <= '0;
            half_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= 1'b0;
            out_ped_reg    <= '0;
            out_dip_reg    <= '0;
            out_peak_reg   <= '0;
            out_half_reg   <= '0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (q_evt.last) begin
                    phase_reg      <= SEEK_PED;
                    prev_reg       <= '0;
                    ref_reg        <= '0;
                    ped_reg        <= '0;
                    dip_reg        <= '0;
                    peak_reg       <= '0;
                    half_reg       <= '0;
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= !found;
                    out_ped_reg    <= found ? ped_prod[IDX_W-1:0]  : '0;
                    out_dip_reg    <= found ? dip_prod[IDX_W-1:0]  : '0;
                    out_peak_reg   <= found ? peak_prod[IDX_W-1:0] : '0;
                    out_half_reg   <= found ? half_prod[IDX_W-1:0] : '0;
                end else begin
                    phase_reg <= phase_next;
                    prev_reg  <= prev_next;
                    ref_reg   <= ref_next;
                    ped_reg   <= ped_next;
                    dip_reg   <= dip_next;
                    peak_reg  <= peak_next;
                    half_reg  <= half_next;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_pedestal = out_ped_reg;
    assign out_dip      = out_dip_reg;
    assign out_peak     = out_peak_reg;
    assign out_half     = out_half_reg;

endmodule

`default_nettype wire

// File: src/hpfs_checker.sv
// Port-level checker for the histogram peak feature scan, with its bind.
`default_nettype none
`include "histogram_peak_feature_scan_macros.svh"

module hpfs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser
);

    logic [72:0] out_word;
    logic [16:0] ped_bin;
    logic [16:0] dip_bin;
    logic [16:0] peak_bin;
    logic [16:0] half_bin;

    // Result fields as the port shows them.
    assign out_word = {m_tuser, m_tdata};
    assign ped_bin  = m_tdata[16:0];
    assign dip_bin  = m_tdata[33:17];
    assign peak_bin = m_tdata[50:34];
    assign half_bin = m_tdata[67:51];

    // A stalled result holds.
    `HPFS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(out_word))

    // A failed scan reports all positions as zero.
    `HPFS_ASSERT(a_fail_zero, m_tvalid && m_tuser |-> m_tdata == 72'd0)

    // Found features are in ascending order.
    `HPFS_ASSERT(a_order, m_tvalid && !m_tuser |-> dip_bin > ped_bin && peak_bin > dip_bin && half_bin >= peak_bin)

    // No result is shown right after reset.
    `HPFS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid)

endmodule

bind histogram_peak_feature_scan hpfs_checker u_hpfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the histogram peak feature scan: streams histograms, predicts reports.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hpfs_pkg::*;

    localparam int unsigned CNT_MAX       = (1 << CNT_W) - 1;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned TAIL_QUIET    = 150;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned RANDOM_ITEMS  = 1450;
    localparam int unsigned PHASE_HISTS   = 3;

    typedef enum logic [2:0] {
        SEEK_PED,
        SEEK_FALL,
        SEEK_DIP,
        SEEK_PEAK,
        SEEK_HALF,
        SCAN_DONE
    } scan_phase_t;

    typedef enum logic [1:0] {
        W_BIN,
        W_CFG,
        W_HOLD
    } word_kind_t;

    typedef struct {
        word_kind_t       kind;
        logic [CNT_W-1:0] count;
        logic             last;
        logic [RF_W-1:0]  rf;
    } pending_t;

    typedef struct {
        logic             status;
        logic [IDX_W-1:0] pedestal;
        logic [IDX_W-1:0] dip;
        logic [IDX_W-1:0] peak;
        logic [IDX_W-1:0] half_max;
    } report_t;

    // Block ports.
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [CNT_W-1:0]  s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [71:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RF_W-1:0]   cfg_data  = '0;

    // Bench bookkeeping.
    pending_t          pending[$];
    report_t           expected_reports[$];
    int unsigned       exp_pushed   = 0;
    int unsigned       res_seen     = 0;
    int unsigned       errors       = 0;
    int unsigned       quiet_cycles = 0;
    logic [31:0]       cyc          = '0;
    logic              hold_req     = 1'b0;
    logic              quiet_tail   = 1'b0;

    // Predicted scan state.
    logic [RF_W-1:0]   rf_cfg   = RF_W'(RF_RESET);
    scan_phase_t       phase    = SEEK_PED;
    logic [SUM_W-1:0]  grp_sum  = '0;
    logic [FILL_W-1:0] fill     = '0;
    logic [IDX_W-1:0]  rb_idx   = '0;
    logic [SUM_W-1:0]  prev_sum = '0;
    logic [SUM_W-1:0]  ref_sum  = '0;
    logic [IDX_W-1:0]  ped_idx  = '0;
    logic [IDX_W-1:0]  dip_idx  = '0;
    logic [IDX_W-1:0]  peak_idx = '0;
    logic [IDX_W-1:0]  half_idx = '0;

    // Stimulus generator state.
    logic [RF_W-1:0]   gen_rf      = RF_W'(RF_RESET);
    int unsigned       gen_items   = 0;

    histogram_peak_feature_scan u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // bin_count[23:0]
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // pedestal_bin, dip_bin, peak_bin, half_max_bin, zeros
        .m_tuser   (m_tuser),   // status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Out-of-range factors saturate: zero acts as one, anything above the maximum as the maximum.
    function automatic int unsigned eff_rebin(input logic [RF_W-1:0] v);
        if (v == 0) return 1;
        if (v > RF_MAX) return RF_MAX;
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] orig_index(input logic [IDX_W-1:0] idx,
                                                    input int unsigned r);
        return IDX_W'(idx * r);
    endfunction

    function automatic void clear_scan();
        phase    = SEEK_PED;
        grp_sum  = '0;
        fill     = '0;
        rb_idx   = '0;
        prev_sum = '0;
        ref_sum  = '0;
        ped_idx  = '0;
        dip_idx  = '0;
        peak_idx = '0;
        half_idx = '0;
    endfunction

    // Advance the predicted scan by one accepted bin word; a last word queues a report.
    function automatic void model_bin(input logic [CNT_W-1:0] count, input logic last);
        int unsigned      r;
        int unsigned      pos;
        logic [SUM_W-1:0] s;
        report_t          rep;
        r   = eff_rebin(rf_cfg);
        pos = rb_idx * r + fill;
        // Words past the histogram capacity are dropped, but their end mark still counts.
        if (pos < MAX_BINS) begin
            grp_sum = grp_sum + count;
            if (fill + 1 >= r) begin
                s       = grp_sum;
                rb_idx  = rb_idx + 1'b1;
                grp_sum = '0;
                fill    = '0;
                case (phase)
                    SEEK_PED: begin
                        if (s != 0) begin
                            ped_idx = rb_idx;
                            phase   = SEEK_FALL;
                        end
                    end
                    SEEK_FALL: begin
                        if (s < prev_sum) phase = SEEK_DIP;
                    end
                    SEEK_DIP: begin
                        if (s > prev_sum) begin
                            dip_idx = rb_idx;
                            phase   = SEEK_PEAK;
                        end
                    end
                    SEEK_PEAK: begin
                        if (s < prev_sum) begin
                            peak_idx = rb_idx;
                            ref_sum  = s;
                            phase    = SEEK_HALF;
                        end
                    end
                    SEEK_HALF: begin
                        if (longint'(s) * 2 < longint'(ref_sum)) begin
                            half_idx = rb_idx;
                            phase    = SCAN_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
                prev_sum = s;
            end else begin
                fill = fill + 1'b1;
            end
        end
        if (last) begin
            if (phase == SEEK_HALF || phase == SCAN_DONE) begin
                rep.status   = 1'b0;
                rep.pedestal = orig_index(ped_idx, r);
                rep.dip      = orig_index(dip_idx, r);
                rep.peak     = orig_index(peak_idx, r);
                rep.half_max = orig_index((phase == SCAN_DONE) ? half_idx : rb_idx, r);
            end else begin
                rep.status   = 1'b1;
                rep.pedestal = '0;
                rep.dip      = '0;
                rep.peak     = '0;
                rep.half_max = '0;
            end
            expected_reports.push_back(rep);
            clear_scan();
        end
    endfunction

    function automatic void check_field(input string name, input logic [IDX_W-1:0] want,
                                        input logic [IDX_W-1:0] got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Driver: bin words, register writes and the hold-off request, in queue order.
    always @(posedge aclk) begin : word_driver
        int unsigned gap_left;
        int unsigned settle;
        logic        bin_taken;
        logic        cfg_taken;
        logic        nv;
        logic        ncv;
        logic        nhold;
        pending_t    head;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            hold_req  <= 1'b0;
            gap_left  = 0;
            settle    = 0;
            rf_cfg    = RF_W'(RF_RESET);
            clear_scan();
        end else begin
            bin_taken = s_tvalid && s_tready;
            cfg_taken = cfg_valid && cfg_ready;
            if (bin_taken) begin
                model_bin(s_tdata, s_tlast);
                if (s_tlast) exp_pushed <= exp_pushed + 1;
            end
            if (cfg_taken) rf_cfg = cfg_data;
            nv    = s_tvalid && !bin_taken;
            ncv   = cfg_valid && !cfg_taken;
            nhold = 1'b0;
            if (!nv && !ncv && pending.size() != 0) begin
                head = pending[0];
                case (head.kind)
                    W_BIN: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else if (!quiet_tail && cyc[7] && $urandom_range(0, 99) < 20) begin
                            gap_left = $urandom_range(0, 4);
                        end else begin
                            nv = 1'b1;
                            s_tdata <= head.count;
                            s_tlast <= head.last;
                            void'(pending.pop_front());
                        end
                    end
                    W_CFG: begin
                        // Write only once every report is in and the block has settled.
                        if (bin_taken || res_seen != exp_pushed) begin
                            settle = 0;
                        end else if (settle < SETTLE_CYCLES) begin
                            settle++;
                        end else begin
                            settle = 0;
                            ncv = 1'b1;
                            cfg_data <= head.rf;
                            void'(pending.pop_front());
                        end
                    end
                    default: begin
                        nhold = 1'b1;
                        void'(pending.pop_front());
                    end
                endcase
            end
            s_tvalid   <= nv;
            cfg_valid  <= ncv;
            hold_req   <= nhold;
            quiet_tail <= (pending.size() < TAIL_QUIET);
        end
    end

    // Monitor: check each report word against the oldest prediction and pace m_tready.
    always @(posedge aclk) begin : report_monitor
        int unsigned stall_left;
        int unsigned gap_left;
        logic        nr;
        report_t     want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
            gap_left   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("report word arrived with no report expected");
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", IDX_W'(want.status), IDX_W'(m_tuser));
                    check_field("pedestal_bin", want.pedestal, m_tdata[IDX_W-1:0]);
                    check_field("dip_bin", want.dip, m_tdata[2*IDX_W-1:IDX_W]);
                    check_field("peak_bin", want.peak, m_tdata[3*IDX_W-1:2*IDX_W]);
                    check_field("half_max_bin", want.half_max, m_tdata[4*IDX_W-1:3*IDX_W]);
                end
                res_seen <= res_seen + 1;
            end
            nr = 1'b1;
            if (hold_req) stall_left = HOLD_CYCLES;
            if (stall_left > 0) begin
                stall_left--;
                nr = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                nr = 1'b0;
            end else if (!quiet_tail && (cyc[8] ^ cyc[5]) && $urandom_range(0, 99) < 20) begin
                gap_left = $urandom_range(0, 4);
                nr = 1'b0;
            end
            m_tready <= nr;
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long.
    always @(posedge aclk) begin : watchdog
        cyc <= cyc + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_bin(input int unsigned count, input bit last);
        pending_t w;
        w.kind  = W_BIN;
        w.count = CNT_W'(count);
        w.last  = last;
        w.rf    = '0;
        pending.push_back(w);
    endtask

    task automatic push_cfg(input logic [RF_W-1:0] v);
        pending_t w;
        w.kind  = W_CFG;
        w.count = '0;
        w.last  = 1'b0;
        w.rf    = v;
        pending.push_back(w);
        gen_rf = v;
    endtask

    // One histogram at the current factor: mostly a pedestal, fall, dip, peak and tail
    // shape, sometimes cut short or plain noise, sometimes with a trailing partial group.
    task automatic add_histogram(input bit short_form);
        int unsigned      r;
        int unsigned      mag;
        int unsigned      ped;
        int unsigned      fall;
        int unsigned      dip;
        int unsigned      top;
        int unsigned      mode;
        int unsigned      e;
        int unsigned      lv[$];
        int unsigned      words[$];
        r    = eff_rebin(gen_rf);
        mag  = (1 << $urandom_range(1, short_form ? 8 : CNT_W)) - 1;
        mode = $urandom_range(0, 99);
        if (mode < 85) begin
            repeat ($urandom_range(0, short_form ? 0 : 2)) lv.push_back(0);
            ped  = $urandom_range(1, mag);
            fall = $urandom_range(0, ped - 1);
            dip  = $urandom_range(fall + 1, mag);
            top  = $urandom_range(dip, mag);
            lv.push_back(ped);
            lv.push_back(fall);
            lv.push_back(dip);
            if (top != dip) lv.push_back(top);
            lv.push_back($urandom_range(0, top - 1));
            repeat ($urandom_range(0, short_form ? 2 : 4)) lv.push_back($urandom_range(0, mag));
            // Broken shape: keep only a prefix.
            if (mode >= 70) begin
                e = $urandom_range(0, lv.size() - 1);
                while (lv.size() > e) void'(lv.pop_back());
            end
        end else begin
            repeat ($urandom_range(0, short_form ? 4 : 10)) lv.push_back($urandom_range(0, mag));
        end
        // Spread each level over its group so the group sum stays r times the level.
        foreach (lv[i]) begin
            e = 0;
            if (r > 1) e = $urandom_range(0, (lv[i] < CNT_MAX - lv[i]) ? lv[i] : CNT_MAX - lv[i]);
            for (int k = 0; k < r; k++) begin
                words.push_back((k == 0) ? lv[i] + e : (k == 1) ? lv[i] - e : lv[i]);
            end
        end
        if (r > 1 && $urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, r - 1)) words.push_back($urandom_range(0, CNT_MAX));
        end
        if (words.size() == 0) words.push_back($urandom_range(0, CNT_MAX));
        foreach (words[i]) push_bin(words[i], i == words.size() - 1);
        gen_items += words.size();
    endtask

    initial begin : stimulus
        logic [RF_W-1:0] fixed_rf[6];
        int unsigned     phase_no;
        int unsigned     hist_no;

        fixed_rf = '{5'd0, 5'd31, 5'd17, 5'd16, 5'd1, 5'd3};

        // At the reset factor of four a lone word is a dropped partial group,
        // and four zero words make one blank bin: both fail the prefit.
        push_bin(CNT_MAX, 1);
        push_bin(0, 0);
        push_bin(0, 0);
        push_bin(0, 0);
        push_bin(0, 1);
        push_cfg(1);
        // Every feature found, with full-scale and zero counts.
        push_bin(0, 0);
        push_bin(CNT_MAX, 0);
        push_bin(5, 0);
        push_bin(9, 0);
        push_bin(3, 0);
        push_bin(1, 1);
        // Flat histogram never falls.
        push_bin(7, 0);
        push_bin(7, 0);
        push_bin(7, 1);
        // Peak found but no half maximum: defaults to the bin count.
        push_bin(4, 0);
        push_bin(2, 0);
        push_bin(6, 0);
        push_bin(5, 0);
        push_bin(5, 1);

        // Long receiver hold-off while short histograms keep coming.
        begin
            pending_t w;
            w.kind  = W_HOLD;
            w.count = '0;
            w.last  = 1'b0;
            w.rf    = '0;
            pending.push_back(w);
        end
        repeat (8) add_histogram(1'b1);

        // Random phases, each at its own rebin factor.
        gen_items = 0;
        phase_no  = 0;
        hist_no   = 0;
        while (gen_items < RANDOM_ITEMS) begin
            if (hist_no % PHASE_HISTS == 0) begin
                if (phase_no < 6) begin
                    push_cfg(fixed_rf[phase_no]);
                end else if ($urandom_range(0, 99) < 70) begin
                    push_cfg(RF_W'($urandom_range(1, 4)));
                end else begin
                    push_cfg(RF_W'($urandom_range(0, 31)));
                end
                phase_no++;
            end
            add_histogram(1'b0);
            hist_no++;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pending.size() != 0 || s_tvalid || cfg_valid || res_seen < exp_pushed);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            $error("%0d expected reports never arrived", expected_reports.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/hpfs_pkg.sv
src/hpfs_front.sv
src/hpfs_queue.sv
src/hpfs_back.sv
src/histogram_peak_feature_scan.sv
src/hpfs_checker.sv
bench/testbench.sv
